>>> src/assert_macros.svh
// assertion macros shared by the encoder rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define TBAE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tbae assertion failed");

`define TBAE_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tbae forbidden condition seen");

`else

`define TBAE_ASSERT(lbl, clk, rst_n, prop)

`define TBAE_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> src/tbae_pkg.sv
// shared types, codes and the component permutation for the triple encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tbae_pkg;

  localparam int ID_WIDTH = 32;
  localparam int FIELD_W  = 32;
  localparam int ORDER_W  = 3;
  localparam int STATUS_W = 3;

  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [ORDER_W-1:0]  order_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam order_t ORD_SPO = 3'd0;
  localparam order_t ORD_SOP = 3'd1;
  localparam order_t ORD_PSO = 3'd2;
  localparam order_t ORD_POS = 3'd3;
  localparam order_t ORD_OSP = 3'd4;
  localparam order_t ORD_OPS = 3'd5;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_ZERO    = 3'd1;
  localparam status_t ST_GAP     = 3'd2;
  localparam status_t ST_PRED    = 3'd3;
  localparam status_t ST_OBJ     = 3'd4;
  localparam status_t ST_REFUSED = 3'd5;
  localparam status_t ST_END     = 3'd6;

  localparam logic ACT_TRIPLE = 1'b0;
  localparam logic ACT_END    = 1'b1;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] subject;
    logic [FIELD_W-1:0] predicate;
    logic [FIELD_W-1:0] object;
  } item_t;

  typedef struct packed {
    logic               y_bit_valid;
    logic               y_bit;
    logic               y_value_valid;
    logic [FIELD_W-1:0] y_value;
    logic               z_bit_valid;
    logic               z_bit;
    logic               z_value_valid;
    logic [FIELD_W-1:0] z_value;
    status_t            status;
  } result_t;

  typedef struct packed {
    id_t x;
    id_t y;
    id_t z;
  } xyz_t;

  // undefined order codes fall back to spo
  function automatic xyz_t permute(order_t ord, id_t s, id_t p, id_t o);
    xyz_t t;
    case (ord)
      ORD_SOP: t = '{x: s, y: o, z: p};
      ORD_PSO: t = '{x: p, y: s, z: o};
      ORD_POS: t = '{x: p, y: o, z: s};
      ORD_OSP: t = '{x: o, y: s, z: p};
      ORD_OPS: t = '{x: o, y: p, z: s};
      default: t = '{x: s, y: p, z: o};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> src/tbae_in_if.sv
// valid/ready channel carrying one triple or end item
// depends on tbae_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tbae_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [tbae_pkg::FIELD_W-1:0] subject;
  logic [tbae_pkg::FIELD_W-1:0] predicate;
  logic [tbae_pkg::FIELD_W-1:0] object;

  modport source (output valid, action, subject, predicate, object, input ready);
  modport sink   (input valid, action, subject, predicate, object, output ready);
endinterface

`default_nettype wire

>>> src/tbae_out_if.sv
// valid/ready channel carrying one encoded result
// depends on tbae_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tbae_out_if;
  logic                         valid;
  logic                         ready;
  logic                         y_bit_valid;
  logic                         y_bit;
  logic                         y_value_valid;
  logic [tbae_pkg::FIELD_W-1:0] y_value;
  logic                         z_bit_valid;
  logic                         z_bit;
  logic                         z_value_valid;
  logic [tbae_pkg::FIELD_W-1:0] z_value;
  logic [tbae_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, y_bit_valid, y_bit, y_value_valid, y_value,
           z_bit_valid, z_bit, z_value_valid, z_value, status,
    input  ready
  );
  modport sink (
    input  valid, y_bit_valid, y_bit, y_value_valid, y_value,
           z_bit_valid, z_bit, z_value_valid, z_value, status,
    output ready
  );
endinterface

`default_nettype wire

>>> src/tbae_encoder.sv
// previous-triple state and the combinational adjacency encode step
// depends on tbae_pkg
`timescale 1ns / 1ps
`default_nettype none

module tbae_encoder (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire tbae_pkg::item_t   item,
  input  wire tbae_pkg::order_t  order,
  output tbae_pkg::result_t      res,
  output logic                   fault
);

  tbae_pkg::id_t prev_first_r, prev_first_nxt;
  tbae_pkg::id_t prev_second_r, prev_second_nxt;
  tbae_pkg::id_t prev_third_r, prev_third_nxt;
  logic          seen_any_r, seen_any_nxt;
  logic          fault_r, fault_nxt;
  tbae_pkg::xyz_t t;

  assign t = tbae_pkg::permute(order,
                               item.subject[tbae_pkg::ID_WIDTH-1:0],
                               item.predicate[tbae_pkg::ID_WIDTH-1:0],
                               item.object[tbae_pkg::ID_WIDTH-1:0]);

  assign fault = fault_r;

  always_comb begin
    res             = '0;
    prev_first_nxt  = prev_first_r;
    prev_second_nxt = prev_second_r;
    prev_third_nxt  = prev_third_r;
    seen_any_nxt    = seen_any_r;
    fault_nxt       = fault_r;
    if (fault_r) begin
      res.status = tbae_pkg::ST_REFUSED;
    end else if (item.action == tbae_pkg::ACT_END) begin
      res.y_bit_valid = 1'b1;
      res.y_bit       = 1'b1;
      res.z_bit_valid = 1'b1;
      res.z_bit       = 1'b1;
      res.status      = tbae_pkg::ST_END;
      seen_any_nxt    = 1'b0;
      prev_first_nxt  = '0;
      prev_second_nxt = '0;
      prev_third_nxt  = '0;
    end else if (t.x == '0 || t.y == '0 || t.z == '0) begin
      res.status = tbae_pkg::ST_ZERO;
    end else if (seen_any_r && t.x == prev_first_r && t.y == prev_second_r) begin
      // same list on both levels: extend z only
      if (t.z <= prev_third_r) begin
        fault_nxt  = 1'b1;
        res.status = tbae_pkg::ST_OBJ;
      end else begin
        res.z_bit_valid   = 1'b1;
        res.z_value_valid = 1'b1;
        res.z_value       = tbae_pkg::FIELD_W'(t.z);
        res.status        = tbae_pkg::ST_OK;
        prev_third_nxt    = t.z;
      end
    end else if (seen_any_r && t.x != prev_first_r &&
                 t.x != prev_first_r + tbae_pkg::id_t'(1)) begin
      fault_nxt  = 1'b1;
      res.status = tbae_pkg::ST_GAP;
    end else if (seen_any_r && t.x == prev_first_r && t.y < prev_second_r) begin
      fault_nxt  = 1'b1;
      res.status = tbae_pkg::ST_PRED;
    end else begin
      // first triple, new x, or new y under the same x
      if (seen_any_r) begin
        res.y_bit_valid = 1'b1;
        res.y_bit       = (t.x != prev_first_r);
        res.z_bit_valid = 1'b1;
        res.z_bit       = 1'b1;
      end
      res.y_value_valid = 1'b1;
      res.y_value       = tbae_pkg::FIELD_W'(t.y);
      res.z_value_valid = 1'b1;
      res.z_value       = tbae_pkg::FIELD_W'(t.z);
      res.status        = tbae_pkg::ST_OK;
      prev_first_nxt    = t.x;
      prev_second_nxt   = t.y;
      prev_third_nxt    = t.z;
      seen_any_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_first_r  <= '0;
      prev_second_r <= '0;
      prev_third_r  <= '0;
      seen_any_r    <= 1'b0;
      fault_r       <= 1'b0;
    end else if (step_en) begin
      prev_first_r  <= prev_first_nxt;
      prev_second_r <= prev_second_nxt;
      prev_third_r  <= prev_third_nxt;
      seen_any_r    <= seen_any_nxt;
      fault_r       <= fault_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/triple_bitmap_adjacency_encoder_core.sv
// top level: input register, encode step, result register and order register
// depends on tbae_pkg, tbae_in_if, tbae_out_if, tbae_encoder, assert_macros.svh
//
//   channel   direction  carries
//   in_ch     sink       action, subject, predicate, object
//   out_ch    source     y/z bits and values, status
//   cfg_*     write      triple_order (3 bits)
//
// one item per cycle sustained while out_ch.ready stays high; items pass the input register, then the result register
// the rate is set by the combinational compare against the stored previous triple
// synchronous active-low reset clears both valid flags, the triple state and the order
// with out_ch.ready low the result holds and one more item waits in the input register
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module triple_bitmap_adjacency_encoder_core (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  tbae_in_if.sink                       in_ch,
  tbae_out_if.source                    out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [tbae_pkg::ORDER_W-1:0] cfg_wdata
);

  tbae_pkg::order_t  order_r;
  tbae_pkg::item_t   item_r;
  logic              s1_vld_r, s1_vld_nxt;
  logic              out_vld_r, out_vld_nxt;
  tbae_pkg::result_t res_r;
  tbae_pkg::result_t res;
  logic              enc_fault;
  logic              s1_adv;
  logic              step_en;
  logic              in_xfer;

  assign s1_adv      = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign step_en     = s1_vld_r && s1_adv;

  assign s1_vld_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = step_en ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  tbae_encoder u_enc (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .order   (order_r),
    .res     (res),
    .fault   (enc_fault)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      order_r   <= tbae_pkg::ORD_SPO;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.action    <= in_ch.action;
      item_r.subject   <= in_ch.subject;
      item_r.predicate <= in_ch.predicate;
      item_r.object    <= in_ch.object;
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.y_bit_valid   = res_r.y_bit_valid;
  assign out_ch.y_bit         = res_r.y_bit;
  assign out_ch.y_value_valid = res_r.y_value_valid;
  assign out_ch.y_value       = res_r.y_value;
  assign out_ch.z_bit_valid   = res_r.z_bit_valid;
  assign out_ch.z_bit         = res_r.z_bit;
  assign out_ch.z_value_valid = res_r.z_value_valid;
  assign out_ch.z_value       = res_r.z_value;
  assign out_ch.status        = res_r.status;

  // an ordering error in the result register means the fault is already latched
  `TBAE_ASSERT(a_err_latches, clk, rst_n, (out_vld_r && (res_r.status == tbae_pkg::ST_GAP || res_r.status == tbae_pkg::ST_PRED || res_r.status == tbae_pkg::ST_OBJ)) |-> enc_fault)
  // once faulted, every step is refused
  `TBAE_ASSERT(a_refuse, clk, rst_n, (step_en && enc_fault) |=> (out_vld_r && res_r.status == tbae_pkg::ST_REFUSED))
  // an ok result always carries a z value
  `TBAE_ASSERT(a_ok_has_z, clk, rst_n, (out_vld_r && res_r.status == tbae_pkg::ST_OK) |-> res_r.z_value_valid)
  // input only stalls when both stages are occupied
  `TBAE_NEVER(a_stall_full, clk, rst_n, !in_ch.ready && !(s1_vld_r && out_vld_r))

endmodule

`default_nettype wire
